FILE: sv/nmea_gga_field_extractor_top_assert.svh
// assertion macros for the gga field extractor
`ifndef NMEA_GGA_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define NGFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NGFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ngfe_pkg.sv
// shared types and constants of the gga field extractor
`default_nettype none

package ngfe_pkg;

  localparam int NBUF      = 5;
  localparam int FIELD_W   = 5;
  localparam int IDX_W     = 4;
  localparam int BUF_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [FIELD_W-1:0] HEADER_MIN = FIELD_W'(5);
  localparam logic [FIELD_W-1:0] CNT_MAX    = '1;
  localparam logic [IDX_W-1:0]   IDX_MAX    = '1;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
  localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C      = 8'h43;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;

  localparam logic [IDX_W-1:0] BUF_SIZE [NBUF] = '{4'd6, 4'd9, 4'd10, 4'd2, 4'd7};
  localparam logic [FIELD_W-1:0] FIELD_RESET [NBUF] = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd9};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME,
    REG_LAT,
    REG_LON,
    REG_SAT,
    REG_ALT
  } reg_idx_t;

  typedef enum logic [2:0] {
    CLS_HDR,
    CLS_A,
    CLS_C,
    CLS_COMMA,
    CLS_STAR,
    CLS_DATA
  } char_cls_t;

  typedef struct packed {
    char_cls_t         cls;
    logic [CHAR_W-1:0] ch;
  } beat_t;

  typedef logic [NBUF-1:0][FIELD_W-1:0] field_sel_t;

  typedef struct packed {
    logic              write_valid;
    logic [BUF_W-1:0]  target_buffer;
    logic [IDX_W-1:0]  write_offset;
    logic [CHAR_W-1:0] write_byte;
    logic              receiving;
    logic              overflow;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/nmea_gga_field_extractor_top.sv
// Picks the characters of selected fields out of a GGA-style sentence stream. One character
// is taken per beat and gives exactly one result beat. Sustained rate is one character per
// cycle while out_ready keeps up; a character is registered in the input stage, then in a
// two-entry queue, then in the output register. The rate is set by the per-character update
// of the field counter, char index and receiving flag in the back end. Field numbers are to be
// written through cfg_we, cfg_index and cfg_data while idle; the block does not enforce this.
`default_nettype none

module nmea_gga_field_extractor_top (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [ngfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ngfe_pkg::FIELD_W-1:0]    cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [ngfe_pkg::CHAR_W-1:0]     rx_char,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            write_valid,
  output logic [ngfe_pkg::BUF_W-1:0]      target_buffer,
  output logic [ngfe_pkg::IDX_W-1:0]      write_offset,
  output logic [ngfe_pkg::CHAR_W-1:0]     write_byte,
  output logic                            receiving,
  output logic                            overflow
);
  import ngfe_pkg::*;

  `include "nmea_gga_field_extractor_top_assert.svh"

  field_sel_t field_sel;
  logic       f_valid;
  logic       f_ready;
  beat_t      f_beat;
  logic       b_valid;
  logic       b_ready;
  beat_t      b_beat;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NBUF; k++) begin
        field_sel[k] <= FIELD_RESET[k];
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME: field_sel[REG_TIME] <= cfg_data;
        REG_LAT:  field_sel[REG_LAT]  <= cfg_data;
        REG_LON:  field_sel[REG_LON]  <= cfg_data;
        REG_SAT:  field_sel[REG_SAT]  <= cfg_data;
        REG_ALT:  field_sel[REG_ALT]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ngfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_char  (rx_char),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_beat   (f_beat)
  );

  ngfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_beat  (f_beat),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_beat   (b_beat)
  );

  ngfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .field_sel (field_sel),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_beat    (b_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign write_valid   = res.write_valid;
  assign target_buffer = res.target_buffer;
  assign write_offset  = res.write_offset;
  assign write_byte    = res.write_byte;
  assign receiving     = res.receiving;
  assign overflow      = res.overflow;

  `NGFE_ASSERT_NOW(a_store_xor_drop, out_valid, !(write_valid && overflow),
    "write and overflow flagged on the same beat")
  `NGFE_ASSERT_NOW(a_idle_result_zero, out_valid && !write_valid && !overflow,
    (target_buffer == '0) && (write_offset == '0) && (write_byte == '0),
    "non-write beat carries write fields")
  `NGFE_ASSERT_NOW(a_store_in_bounds, out_valid && write_valid,
    (target_buffer < BUF_W'(NBUF)) && (write_offset < BUF_SIZE[target_buffer]),
    "stored write falls outside its buffer")
  `NGFE_ASSERT_NEXT(a_stalled_queue_holds, b_valid && !b_ready,
    b_valid && $stable(b_beat), "queue head changed while back end stalled")

endmodule

`default_nettype wire

FILE: sv/ngfe_front.sv
// input stage: takes characters and classifies them
`default_nettype none

module ngfe_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [ngfe_pkg::CHAR_W-1:0] rx_char,
  output logic                       q_valid,
  input  wire                        q_ready,
  output ngfe_pkg::beat_t            q_beat
);
  import ngfe_pkg::*;

  logic      fv;
  beat_t     fbeat;
  char_cls_t cls;

  always_comb begin
    unique case (rx_char) inside
      CH_DOLLAR, CH_G, CH_P: cls = CLS_HDR;
      CH_A:                  cls = CLS_A;
      CH_C:                  cls = CLS_C;
      CH_COMMA:              cls = CLS_COMMA;
      CH_STAR:               cls = CLS_STAR;
      default:               cls = CLS_DATA;
    endcase
  end

  assign in_ready = !fv || q_ready;
  assign q_valid  = fv;
  assign q_beat   = fbeat;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (q_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fbeat.cls <= cls;
      fbeat.ch  <= rx_char;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ngfe_queue.sv
// short queue of classified beats between front and back
`default_nettype none

module ngfe_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push_valid,
  output logic            push_ready,
  input  ngfe_pkg::beat_t push_beat,
  output logic            pop_valid,
  input  wire             pop_ready,
  output ngfe_pkg::beat_t pop_beat
);
  import ngfe_pkg::*;

  beat_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_beat   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ngfe_back.sv
// field tracking state and registered result
`default_nettype none

module ngfe_back (
  input  wire                  clk,
  input  wire                  rst,
  input  ngfe_pkg::field_sel_t field_sel,
  input  wire                  q_valid,
  output logic                 q_ready,
  input  ngfe_pkg::beat_t      q_beat,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ngfe_pkg::result_t    res
);
  import ngfe_pkg::*;

  logic [FIELD_W-1:0] field_counter;
  logic [FIELD_W-1:0] field_counter_next;
  logic [IDX_W-1:0]   char_index;
  logic [IDX_W-1:0]   char_index_next;
  logic               receiving_flag;
  logic               receiving_flag_next;
  logic [FIELD_W-1:0] cnt_bump;
  logic               hit;
  logic [BUF_W-1:0]   hit_buf;
  result_t            res_next;
  logic               pop;

  assign q_ready  = !out_valid || out_ready;
  assign pop      = q_valid && q_ready;
  assign cnt_bump = (field_counter == CNT_MAX) ? field_counter : field_counter + 1'b1;

  // lowest buffer number wins
  always_comb begin
    hit     = 1'b0;
    hit_buf = '0;
    for (int k = NBUF - 1; k >= 0; k--) begin
      if (field_sel[k] == field_counter) begin
        hit     = 1'b1;
        hit_buf = BUF_W'(k);
      end
    end
  end

  always_comb begin
    field_counter_next  = field_counter;
    char_index_next     = char_index;
    receiving_flag_next = receiving_flag;
    res_next            = '0;
    unique case (q_beat.cls)
      CLS_HDR: begin
        field_counter_next  = cnt_bump;
        receiving_flag_next = 1'b0;
      end
      CLS_A: begin
        if (field_counter >= HEADER_MIN) begin
          receiving_flag_next = 1'b1;
        end
        field_counter_next = '0;
        char_index_next    = '0;
      end
      CLS_C: begin
        field_counter_next = '0;
        char_index_next    = '0;
      end
      CLS_COMMA: begin
        field_counter_next = cnt_bump;
        char_index_next    = '0;
      end
      CLS_STAR: begin
        field_counter_next  = '0;
        char_index_next     = '0;
        receiving_flag_next = 1'b0;
      end
      CLS_DATA: begin
        if (receiving_flag && hit) begin
          res_next.target_buffer = hit_buf;
          res_next.write_offset  = char_index;
          res_next.write_byte    = q_beat.ch;
          if (char_index < BUF_SIZE[hit_buf]) begin
            res_next.write_valid = 1'b1;
          end else begin
            res_next.overflow = 1'b1;
          end
          if (char_index != IDX_MAX) begin
            char_index_next = char_index + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_next.receiving = receiving_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter  <= '0;
      char_index     <= '0;
      receiving_flag <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        field_counter  <= field_counter_next;
        char_index     <= char_index_next;
        receiving_flag <= receiving_flag_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
